### hdl/srpq_pkg.sv
// ----------------------------------------------------------------------------
// srpq_pkg
// Shared types and codes for the sorted ring priority queue.
// ----------------------------------------------------------------------------
package srpq_pkg;

  localparam int SRPQ_DEPTH = 16;

  // Operation field codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Status field codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic              operation;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic [1:0]         status;
    logic [4:0]         count;
    logic               is_empty;
    logic               is_full;
  } rsp_t;

  // Command broadcast to every cell
  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t            op;
    logic signed [31:0] value;
  } cmd_t;

endpackage

### hdl/srpq_cell.sv
// ----------------------------------------------------------------------------
// srpq_cell
// One slot of the sorted chain: compares against the broadcast value and
// shifts toward the tail on insert or toward the head on removal.
// ----------------------------------------------------------------------------
module srpq_cell (
  input  logic               clk,
  input  logic               rst,
  input  srpq_pkg::cmd_t     cmd,
  input  logic signed [31:0] left_value,
  input  logic               left_valid,
  input  logic               left_keep,
  input  logic signed [31:0] right_value,
  input  logic               right_valid,
  output logic signed [31:0] value,
  output logic               valid,
  output logic               keep
);
  import srpq_pkg::*;

  // Stay put when holding a value greater than or equal to the new one
  assign keep = valid && !($signed(cmd.value) > $signed(value));

  always_ff @(posedge clk) begin
    case (cmd.op)
      CMD_INSERT: begin
        if (!keep) begin
          value <= left_keep ? cmd.value : left_value;
        end
      end
      CMD_REMOVE: begin
        value <= right_value;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (cmd.op)
        CMD_INSERT: begin
          if (!keep) begin
            valid <= left_valid;
          end
        end
        CMD_REMOVE: begin
          valid <= right_valid;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### hdl/sorted_ring_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_ring_priority_queue
// Priority queue of signed 32-bit values held in descending order.
// ----------------------------------------------------------------------------
// The queue takes one transaction per cycle while the result register is free
// or drains; the result is registered and shows in the cycle after acceptance.
// Every cell compares its own value against the broadcast insert value and
// looks only at its direct neighbors, so insert and removal work the same way
// regardless of DEPTH. Cell 0 always holds the largest value; an insert lands
// after every stored value greater than or equal to it, so equal values
// leave first in first out. An insert into a full queue is dropped with
// status 1, a removal from an empty queue returns status 2; in both cases
// out_value is zero and the contents stay as they were. The count field is
// five bits wide and shows the low bits of the occupancy for larger DEPTH.
// No clearing pass is needed after reset: slot contents are qualified by a
// per-cell valid bit.
// ----------------------------------------------------------------------------
module sorted_ring_priority_queue #(
  parameter int DEPTH = srpq_pkg::SRPQ_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  srpq_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output srpq_pkg::rsp_t rsp
);
  import srpq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  logic               fire;
  logic               is_full_now;
  logic               is_empty_now;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [CNT_W+4:0]   count_ext;
  cmd_t               cmd;
  rsp_t               rsp_next;

  logic signed [31:0] cell_value [DEPTH];
  logic [DEPTH-1:0]   cell_valid;
  logic [DEPTH-1:0]   cell_keep;

  // Accept a new transaction whenever the result register is free or drains
  assign req_ready    = !rsp_valid || rsp_ready;
  assign fire         = req_valid && req_ready;
  assign is_full_now  = (count == CNT_FULL);
  assign is_empty_now = (count == '0);

  // Decode the accepted transaction into a chain command
  always_comb begin
    cmd.value  = req.value;
    cmd.op     = CMD_HOLD;
    count_next = count;
    rsp_next.out_value = '0;
    rsp_next.status    = ST_DONE;
    if (fire) begin
      unique case (req.operation)
        OP_INSERT: begin
          if (is_full_now) begin
            rsp_next.status = ST_FULL;
          end else begin
            cmd.op     = CMD_INSERT;
            count_next = count + CNT_ONE;
          end
        end
        OP_REMOVE: begin
          if (is_empty_now) begin
            rsp_next.status = ST_EMPTY;
          end else begin
            cmd.op             = CMD_REMOVE;
            count_next         = count - CNT_ONE;
            rsp_next.out_value = cell_value[0];
          end
        end
        default: begin
        end
      endcase
    end
    count_ext         = {5'b0, count_next};
    rsp_next.count    = count_ext[4:0];
    rsp_next.is_empty = (count_next == '0);
    rsp_next.is_full  = (count_next == CNT_FULL);
  end

  // Chain of cells: cell 0 is the head, cell DEPTH-1 the tail end
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] lv;
    logic               lval;
    logic               lkeep;
    logic signed [31:0] rv;
    logic               rval;

    if (i == 0) begin : g_head
      assign lv    = '0;
      assign lval  = 1'b1;
      assign lkeep = 1'b1;
    end else begin : g_body
      assign lv    = cell_value[i-1];
      assign lval  = cell_valid[i-1];
      assign lkeep = cell_keep[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign rv   = '0;
      assign rval = 1'b0;
    end else begin : g_mid
      assign rv   = cell_value[i+1];
      assign rval = cell_valid[i+1];
    end

    srpq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .left_value  (lv),
      .left_valid  (lval),
      .left_keep   (lkeep),
      .right_value (rv),
      .right_valid (rval),
      .value       (cell_value[i]),
      .valid       (cell_valid[i]),
      .keep        (cell_keep[i])
    );
  end

  // Occupancy and result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Load the result register on acceptance; hold it while stalled
  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= rsp_next;
    end
  end

  // Valid bits form a prefix; their count must match the occupancy
  a_count_matches_valid : assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == int'(count))
    else $error("cell valid bits disagree with occupancy count");

  a_count_bounded : assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("occupancy count exceeds depth");

  // Head pair stays in descending order
  a_head_sorted : assert property (@(posedge clk) disable iff (rst)
    cell_valid[1] |-> !($signed(cell_value[1]) > $signed(cell_value[0])))
    else $error("head cells out of order");

  a_full_drop_flag : assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == ST_FULL) |-> rsp.is_full)
    else $error("dropped insert reported without full flag");

  a_empty_drop_flag : assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == ST_EMPTY) |-> (rsp.is_empty && rsp.out_value == '0))
    else $error("empty removal reported with data or without empty flag");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted ring priority queue.
// ----------------------------------------------------------------------------
// A scoreboard keeps its own sorted copy of the queue contents, works out the
// expected response for every accepted request transaction, and checks each
// accepted response field by field in order. A short directed sequence covers
// the field extremes, equal values, a full and an empty queue, and a drop in
// both cases. Random bursts with a wandering insert/remove mix follow, under
// three idle patterns on the request and response channels.
// ----------------------------------------------------------------------------
module tb_top;
  import srpq_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 7;
  localparam int PHASE_ITEMS    = 410;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int MAX_REPORTS    = 10;

  // --------------------------------------------------------------------------
  // Scoreboard: sorted shadow of the queue plus the responses still owed.
  // --------------------------------------------------------------------------
  class pq_scoreboard;
    logic signed [31:0] held[$];    // largest first, equal values in arrival order
    rsp_t               owed[$];
    int unsigned        failures;
    int unsigned        n_insert, n_remove, n_full_drop, n_empty_drop;
    int unsigned        n_drained, peak;

    function void report(string msg);
      if (failures < MAX_REPORTS) $display("[%0t] ERROR: %s", $realtime, msg);
      failures++;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // Apply one accepted request to the shadow and queue its expected response.
    function void note_request(req_t r);
      rsp_t exp_rsp;
      int   pos;
      exp_rsp = '0;
      if (r.operation == OP_INSERT) begin
        n_insert++;
        if (held.size() >= SRPQ_DEPTH) begin
          exp_rsp.status = ST_FULL;
          n_full_drop++;
        end else begin
          // Walk back from the tail past every smaller value.
          pos = held.size();
          while (pos > 0 && r.value > held[pos-1]) pos--;
          held.insert(pos, r.value);
        end
      end else begin
        n_remove++;
        if (held.size() == 0) begin
          exp_rsp.status = ST_EMPTY;
          n_empty_drop++;
        end else begin
          exp_rsp.out_value = held.pop_front();
          if (held.size() == 0) n_drained++;
        end
      end
      exp_rsp.count    = 5'(held.size());
      exp_rsp.is_empty = (held.size() == 0);
      exp_rsp.is_full  = (held.size() >= SRPQ_DEPTH);
      if (held.size() > peak) peak = held.size();
      owed.push_back(exp_rsp);
    endfunction

    // Compare one accepted response against the oldest expectation.
    function void check_response(rsp_t r);
      rsp_t e;
      if (owed.size() == 0) begin
        report($sformatf("response with nothing expected: value=%0d status=%0d count=%0d",
                         r.out_value, r.status, r.count));
        return;
      end
      e = owed.pop_front();
      if (r.out_value !== e.out_value || r.status !== e.status || r.count !== e.count ||
          r.is_empty !== e.is_empty || r.is_full !== e.is_full)
        report($sformatf({"response mismatch: exp value=%0d status=%0d count=%0d empty=%0b ",
                          "full=%0b, got value=%0d status=%0d count=%0d empty=%0b full=%0b"},
                         e.out_value, e.status, e.count, e.is_empty, e.is_full,
                         r.out_value, r.status, r.count, r.is_empty, r.is_full));
    endfunction
  endclass

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  pq_scoreboard sb = new();

  // Idle percentages for each side; changed only while the queue is quiet.
  int snd_idle = 33;
  int rcv_idle = 66;
  int quiet_cycles = 0;

  sorted_ring_priority_queue uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Drop response ready at random; rcv_idle sets how often.
  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= rcv_idle);
  end

  // Monitor both channels at the clock edge and run the watchdog. Note the
  // request before checking the response so a same-edge pair stays ordered.
  always @(posedge clk) begin
    logic moved;
    moved = 1'b0;
    if (!rst) begin
      if (req_valid && req_ready) begin
        sb.note_request(req);
        moved = 1'b1;
      end
      if (rsp_valid && rsp_ready) begin
        sb.check_response(rsp);
        moved = 1'b1;
      end
      if (moved) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles, %0d responses outstanding",
                 WATCHDOG_LIMIT, sb.pending());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Present one request, idling first at random, and hold it until accepted.
  // Call right after a rising edge; returns right after the accepting edge
  // with valid still high, so back-to-back transactions need no lowering.
  task automatic send_req(input logic op, input logic signed [31:0] val);
    req_t item;
    item.operation = op;
    item.value     = val;
    while ($urandom_range(99) < snd_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  // Hold off the sender until every owed response has come back. Sample the
  // scoreboard on the falling edge so the monitor has settled for the cycle.
  task automatic drain_queue();
    req_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Mostly full-range values, with clusters of small values to force ties
  // and a share of values at or near both extremes.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return $urandom;
      5, 6, 7:       return int'($urandom_range(8)) - 4;
      8:             return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default:       return $urandom_range(1) ? 32'sh7fffffff - int'($urandom_range(3))
                                              : 32'sh80000000 + int'($urandom_range(3));
    endcase
  endfunction

  initial begin
    logic signed [31:0] fill_vals[$];
    int ph;
    int sent;
    int ins_pct;

    fill_vals = '{
      32'sh7fffffff, 32'sh80000000, -32'sd1, 32'sd0, 32'sd5, 32'sd5,
      -32'sd7, 32'sh40000000, 32'shbfffffff, 32'sd3, 32'sd3, -32'sd1,
      32'sd100, -32'sd100, 32'sd7, 32'sh7fffffff
    };

    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: removal from an empty queue, insert into empty, fill to
    // capacity with both extremes and ties, drop an insert while full,
    // then pull the largest values back out.
    send_req(OP_REMOVE, $urandom);
    foreach (fill_vals[i]) send_req(OP_INSERT, fill_vals[i]);
    send_req(OP_INSERT, 32'sd42);
    repeat (7) send_req(OP_REMOVE, $urandom);
    drain_queue();

    // Random bursts, each with its own insert share so occupancy swings
    // between empty and full. Pause for a full drain between idle patterns.
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin snd_idle = 33; rcv_idle = 66; end
        1: begin snd_idle = 66; rcv_idle = 33; end
        default: begin snd_idle = 0; rcv_idle = 0; end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        case ($urandom_range(4))
          0: ins_pct = 90;
          1: ins_pct = 70;
          2: ins_pct = 50;
          3: ins_pct = 30;
          default: ins_pct = 10;
        endcase
        repeat ($urandom_range(60, 20)) begin
          send_req(($urandom_range(99) < ins_pct) ? OP_INSERT : OP_REMOVE, pick_value());
          sent++;
        end
      end
      drain_queue();
    end

    // Let any stray response surface before judging.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d responses never arrived", sb.pending()));

    $display("Covered %0d inserts (%0d dropped while full) and %0d removals (%0d from empty).",
             sb.n_insert, sb.n_full_drop, sb.n_remove, sb.n_empty_drop);
    $display("Peak occupancy %0d of %0d, queue emptied by removal %0d times, %0d failures.",
             sb.peak, SRPQ_DEPTH, sb.n_drained, sb.failures);
    if (sb.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
hdl/srpq_pkg.sv
hdl/srpq_cell.sv
hdl/sorted_ring_priority_queue.sv
tb/tb_top.sv
